>>> rtl/bldq_pkg.sv
`timescale 1ns / 1ps
// Package for the bounded deque with search: action and status codes,
// and the packed input and result words. No dependencies.
package bldq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_BACK   = 2'd2,
    ACT_SEARCH     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    action_t                    action;
    logic signed [VALUE_W-1:0]  value;
  } in_word_t;

  typedef struct packed {
    status_t              status;
    logic                 found;
    logic [COUNT_W-1:0]   count;
    logic                 is_empty;
  } out_word_t;

endpackage

>>> rtl/bounded_list_deque_with_search.sv
`timescale 1ns / 1ps
// Top level of the bounded deque with membership search.
// Depends on bldq_pkg for the word types and codes.

// A push or a pop passes from acceptance to the finish state, which offers its
// result word once the output register is free. A search first walks the held
// values in the scan state and then finishes the same way. The single memory
// read port feeds one compare per cycle while the held entries are walked from
// front to back, and a match ends the walk early. A search of an empty store
// skips the walk and goes straight to the finish state. The block takes one
// word at a time; in_ready is high while no word is being worked on, and a
// finished result may wait in the output register while the next word is
// accepted. A result that is still waiting when the next one is finished holds
// the block until out_ready takes it. The store needs no clearing after reset.
module bounded_list_deque_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bldq_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bldq_pkg::out_word_t out_data
);
  import bldq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + (AW+1)'(off);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic signed [VALUE_W-1:0] mem [DEPTH];

  state_t                    state_r;
  logic [AW-1:0]             head_r;
  logic [CW-1:0]             cnt_r;
  logic [CW-1:0]             idx_r;
  logic                      cmp_vld_r;
  logic signed [VALUE_W-1:0] key_r;
  logic signed [VALUE_W-1:0] rd_data_r;
  status_t                   res_status_r;
  logic                      res_found_r;
  logic                      out_valid_r;
  out_word_t                 out_data_r;

  logic                      accept;
  logic                      full;
  logic                      issue;
  logic                      hit;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [AW-1:0]             head_dec;
  logic [AW-1:0]             rd_addr;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign full      = (cnt_r == CW'(DEPTH));
  assign issue     = (idx_r < cnt_r);
  assign hit       = cmp_vld_r && (rd_data_r == key_r);
  assign head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign rd_addr   = ring_add(head_r, idx_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ring_add(head_r, cnt_r);
    if (accept && !full) begin
      if (in_data.action == ACT_PUSH_FRONT) begin
        wr_en   = 1'b1;
        wr_addr = head_dec;
      end else if (in_data.action == ACT_PUSH_BACK) begin
        wr_en   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data.value;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      cnt_r        <= '0;
      idx_r        <= '0;
      cmp_vld_r    <= 1'b0;
      res_status_r <= ST_DONE;
      res_found_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_found_r  <= 1'b0;
            key_r        <= in_data.value;
            idx_r        <= '0;
            cmp_vld_r    <= 1'b0;
            case (in_data.action)
              ACT_PUSH_FRONT: begin
                state_r <= S_FIN;
                if (full) begin
                  res_status_r <= ST_FULL;
                end else begin
                  res_status_r <= ST_DONE;
                  head_r       <= head_dec;
                  cnt_r        <= cnt_r + CW'(1);
                end
              end
              ACT_PUSH_BACK: begin
                state_r <= S_FIN;
                if (full) begin
                  res_status_r <= ST_FULL;
                end else begin
                  res_status_r <= ST_DONE;
                  cnt_r        <= cnt_r + CW'(1);
                end
              end
              ACT_POP_BACK: begin
                state_r <= S_FIN;
                if (cnt_r == '0) begin
                  res_status_r <= ST_EMPTY;
                end else begin
                  res_status_r <= ST_DONE;
                  cnt_r        <= cnt_r - CW'(1);
                end
              end
              default: begin
                res_status_r <= ST_DONE;
                if (cnt_r != '0) begin
                  state_r <= S_SCAN;
                end else begin
                  state_r <= S_FIN;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          cmp_vld_r <= issue && !hit;
          if (issue) begin
            idx_r <= idx_r + CW'(1);
          end
          if (hit) begin
            res_found_r <= 1'b1;
            state_r     <= S_FIN;
          end else if (!issue) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r         <= 1'b1;
            out_data_r.status   <= res_status_r;
            out_data_r.found    <= res_found_r;
            out_data_r.count    <= COUNT_W'(cnt_r);
            out_data_r.is_empty <= (cnt_r == '0);
            state_r             <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("held count exceeds depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> cnt_r != '0)
    else $error("search walk entered with an empty store");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result word raised outside the finish state");

  a_found_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.found |-> out_data_r.status == ST_DONE)
    else $error("found flag set on a rejected word");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r <= cnt_r)
    else $error("search index ran past the held count");

endmodule

>>> bench/bldq_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the bounded deque with search: tracks the deque contents from the
// accepted input words and compares every accepted result word with its prediction.
// Depends on bldq_pkg for the word types and codes.
module bldq_result_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bldq_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bldq_pkg::out_word_t out_data,
  output int unsigned         mismatch_count,
  output int unsigned         pending_results
);
  import bldq_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic [VALUE_W-1:0] ring [DEPTH];
  logic [IDX_W-1:0]   front_pos;
  logic [COUNT_W-1:0] held;
  out_word_t          awaited_results [$];

  function automatic int unsigned ring_slot(int unsigned offset);
    return (int'(front_pos) + offset) % DEPTH;
  endfunction

  function automatic out_word_t deque_apply(in_word_t w);
    out_word_t r;
    r = '0;
    r.status = ST_DONE;
    case (w.action)
      ACT_PUSH_FRONT: begin
        if (held == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          front_pos = (front_pos == 0) ? IDX_W'(DEPTH - 1) : front_pos - 1'b1;
          ring[front_pos] = w.value;
          held = held + 1'b1;
        end
      end
      ACT_PUSH_BACK: begin
        if (held == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring[ring_slot(held)] = w.value;
          held = held + 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          held = held - 1'b1;
        end
      end
      default: begin
        for (int unsigned i = 0; i < held; i++) begin
          if (ring[ring_slot(i)] == w.value) begin
            r.found = 1'b1;
          end
        end
      end
    endcase
    r.count = held;
    r.is_empty = (held == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      front_pos = '0;
      held = '0;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result word with nothing awaited", 32'(out_data), 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.found !== want.found)
            report_mismatch("found", 32'(out_data.found), 32'(want.found));
          if (out_data.count !== want.count)
            report_mismatch("count", 32'(out_data.count), 32'(want.count));
          if (out_data.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(out_data.is_empty), 32'(want.is_empty));
        end
      end
      if (in_valid && in_ready) begin
        awaited_results = {awaited_results, deque_apply(in_data)};
      end
    end
    pending_results <= awaited_results.size();
  end

endmodule

>>> bench/bounded_list_deque_with_search_tb.sv
`timescale 1ns / 1ps
// Testbench top for the bounded deque with search: clock, reset, directed and random
// input words, random output stalls, watchdog and verdict.
// Depends on bldq_pkg, bounded_list_deque_with_search and bldq_result_checker.
module bounded_list_deque_with_search_tb;
  import bldq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RANDOM_WORDS = 1700;
  localparam int unsigned STALL_LIMIT  = 2000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_word_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned idle_cycles = 0;
  bit          in_calm     = 1'b0;
  bit          out_calm    = 1'b0;

  bounded_list_deque_with_search #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  bldq_result_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned gap;
    forever begin
      gap = out_calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  task automatic send_word(action_t act, logic [VALUE_W-1:0] val);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.action <= act;
    in_data.value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 7);
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned mix;
    int unsigned pick;
    int unsigned push_pct;
    int unsigned pop_pct;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_word(ACT_POP_BACK, 32'hDEAD_BEEF);
    send_word(ACT_SEARCH, 32'h0000_0000);
    send_word(ACT_PUSH_FRONT, 32'h8000_0000);
    send_word(ACT_PUSH_BACK, 32'h7FFF_FFFF);
    send_word(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
    send_word(ACT_PUSH_BACK, 32'h0000_0000);
    send_word(ACT_SEARCH, 32'h7FFF_FFFF);
    send_word(ACT_SEARCH, 32'h8000_0000);
    send_word(ACT_SEARCH, 32'h1234_5678);
    send_word(ACT_POP_BACK, 32'h5555_5555);
    send_word(ACT_SEARCH, 32'h0000_0000);
    send_word(ACT_PUSH_BACK, 32'hAAAA_AAAA);
    for (int k = 0; k < 12; k++) begin
      send_word((k % 2 == 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, 32'(k + 100));
    end
    send_word(ACT_PUSH_FRONT, 32'h0000_0001);
    send_word(ACT_PUSH_BACK, 32'h0000_0002);
    send_word(ACT_SEARCH, 32'hAAAA_AAAA);

    // Blocks of words lean toward filling, draining or a balanced mix so that the
    // deque visits both the full and the empty boundary many times.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        mix = $urandom_range(0, 2);
        in_calm = ($urandom_range(0, 4) == 0);
        out_calm = ($urandom_range(0, 4) == 0);
      end
      if (n == RANDOM_WORDS / 2) begin
        drain_results();
      end
      push_pct = (mix == 0) ? 60 : (mix == 1) ? 20 : 40;
      pop_pct = (mix == 0) ? 15 : (mix == 1) ? 55 : 30;
      pick = $urandom_range(0, 99);
      if (pick < push_pct) begin
        send_word($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, pick_value());
      end else if (pick < push_pct + pop_pct) begin
        send_word(ACT_POP_BACK, $urandom);
      end else begin
        send_word(ACT_SEARCH, pick_value());
      end
    end

    drain_results();
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bldq_pkg.sv
rtl/bounded_list_deque_with_search.sv
bench/bldq_result_checker.sv
bench/bounded_list_deque_with_search_tb.sv
